### sv/wsdf_pkg.sv
// Shared types, codes and helpers for the WebSocket frame deframer.
package wsdf_pkg;

    // Opcodes recognized in the first header byte
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // Seven-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_EXT16 = 7'h7E;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'h7F;

    // Largest payload of a control frame
    localparam logic [63:0] CTRL_MAX_LEN = 64'd125;

    // Reset value of the payload limit
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

    // Header byte counts
    localparam logic [3:0] HDR_BASE_BYTES  = 4'd2;
    localparam logic [3:0] HDR_EXT16_BYTES = 4'd2;
    localparam logic [3:0] HDR_EXT64_BYTES = 4'd8;
    localparam logic [3:0] HDR_MASK_BYTES  = 4'd4;

    // Result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Header status codes
    typedef enum logic [2:0] {
        ST_GOOD       = 3'd0,
        ST_BAD_OPCODE = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_LONG_CTRL  = 3'd3,
        ST_RSV23      = 3'd4,
        ST_RSV1       = 3'd5,
        ST_FRAG_CTRL  = 3'd6
    } status_t;

    // Parser phase, one-hot
    typedef enum logic [1:0] {
        PH_HEADER  = 2'b01,
        PH_PAYLOAD = 2'b10
    } phase_t;

    // One result item
    typedef struct packed {
        logic        kind;
        status_t     status;
        logic [3:0]  opcode;
        logic        fin;
        logic        rsv1;
        logic        masked;
        logic [31:0] payload_length;
        logic [7:0]  payload_data;
        logic        last;
    } wsdf_result_t;

    // Saturate a 64-bit length to 32 bits
    function automatic logic [31:0] sat_len(input logic [63:0] len);
        logic [31:0] res;
        begin
            res = (len[63:32] != 32'd0) ? 32'hFFFF_FFFF : len[31:0];
            return res;
        end
    endfunction

    // Number of extended length bytes for a second header byte
    function automatic logic [3:0] ext_bytes(input logic [7:0] sec);
        logic [3:0] res;
        begin
            if (sec[6:0] == LEN_CODE_EXT16) begin
                res = HDR_EXT16_BYTES;
            end else if (sec[6:0] == LEN_CODE_EXT64) begin
                res = HDR_EXT64_BYTES;
            end else begin
                res = 4'd0;
            end
            return res;
        end
    endfunction

endpackage

### sv/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: stream ports, parser and output buffer.
//
//  channel   direction  ports                               transaction
//  s_        in         s_tvalid s_tready s_tdata[7:0]      one raw stream byte
//  m_        out        m_tvalid m_tready m_tdata[55:0]     header descriptor or
//                       m_tuser m_tlast                     unmasked payload byte
//  cfg_      in         cfg_we cfg_wdata[31:0]              max_payload write
//
// One byte per cycle while s_tready is high; each result is registered in the skid block.
// The longest path is the header check: a 64-bit length compare against max_payload.
// Reset clears all frame state and sets max_payload to 1048576.
// With m_tready low a second result parks in the skid stage; s_tready then drops
// until the output drains. After a bad header every byte is taken and dropped.
module websocket_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [6:3] opcode, [7] fin, [8] rsv1, [9] masked,
    // [41:10] payload_length, [49:42] payload_data, [55:50] zero
    output logic [55:0] m_tdata,
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast    // [0] last
);
    import wsdf_pkg::*;

    logic         s_accept;
    logic         res_valid;
    wsdf_result_t res;
    wsdf_result_t out_res;

    assign s_accept = s_tvalid && s_tready;

    wsdf_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (s_accept),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    wsdf_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    // Pack the result onto the stream ports
    assign m_tdata = {6'd0, out_res.payload_data, out_res.payload_length, out_res.masked,
                      out_res.rsv1, out_res.fin, out_res.opcode, out_res.status};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

    // A full skid stage implies a held output
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("skid stage full without a pending output");

    // Payload results never carry a bad status
    a_payload_good: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.kind == KIND_PAYLOAD) |-> (res.status == ST_GOOD))
        else $error("payload result with nonzero status");

    // A bad header closes its frame
    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status != ST_GOOD) |-> res.last)
        else $error("bad header descriptor without last");

    // Nothing follows a bad header
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status != ST_GOOD) |=> !res_valid)
        else $error("result produced after a bad header");

endmodule

### sv/wsdf_parser.sv
// Header gathering, header checks and payload unmasking, one byte per transaction.
module wsdf_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_wdata,
    input  logic                  in_accept,
    input  logic [7:0]            in_byte,
    output logic                  res_valid,
    output wsdf_pkg::wsdf_result_t res
);
    import wsdf_pkg::*;

    logic [31:0] max_payload_reg;
    phase_t      phase_reg, phase_next;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  second_reg, second_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] remain_reg, remain_next;
    logic [1:0]  key_idx_reg, key_idx_next;
    logic        halted_reg, halted_next;

    // Decode the current header byte position and compute the next state
    always_comb begin
        logic [7:0]  fb_cur;
        logic [7:0]  sb_cur;
        logic [3:0]  ext_cur;
        logic [3:0]  cnt_inc;
        logic [3:0]  total;
        logic [3:0]  op;
        logic        is_ctrl;
        logic        is_data;
        logic [7:0]  key_byte;
        status_t     st;

        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        len_next     = len_reg;
        key_next     = key_reg;
        remain_next  = remain_reg;
        key_idx_next = key_idx_reg;
        halted_next  = halted_reg;
        res_valid    = 1'b0;

        res.kind           = KIND_PAYLOAD;
        res.status         = ST_GOOD;
        res.opcode         = first_reg[3:0];
        res.fin            = first_reg[7];
        res.rsv1           = first_reg[6];
        res.masked         = second_reg[7];
        res.payload_length = sat_len(len_reg);
        res.payload_data   = 8'd0;
        res.last           = 1'b0;

        fb_cur   = (hdr_cnt_reg == 4'd0) ? in_byte : first_reg;
        sb_cur   = (hdr_cnt_reg == 4'd1) ? in_byte : second_reg;
        ext_cur  = ext_bytes(sb_cur);
        cnt_inc  = hdr_cnt_reg + 4'd1;
        total    = HDR_BASE_BYTES + ext_cur + (sb_cur[7] ? HDR_MASK_BYTES : 4'd0);
        op       = fb_cur[3:0];
        is_ctrl  = (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
        is_data  = (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN);
        key_byte = 8'd0;
        st       = ST_GOOD;

        if (in_accept && !halted_reg) begin
            unique case (phase_reg)
                PH_PAYLOAD: begin
                    // Unmask one payload byte and count down
                    unique case (key_idx_reg)
                        2'd0:    key_byte = key_reg[31:24];
                        2'd1:    key_byte = key_reg[23:16];
                        2'd2:    key_byte = key_reg[15:8];
                        default: key_byte = key_reg[7:0];
                    endcase
                    if (!second_reg[7]) begin
                        key_byte = 8'd0;
                    end
                    res_valid        = 1'b1;
                    res.payload_data = in_byte ^ key_byte;
                    res.last         = (remain_reg == 32'd1);
                    key_idx_next     = key_idx_reg + 2'd1;
                    remain_next      = remain_reg - 32'd1;
                    if (remain_reg == 32'd1) begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    // Gather header bytes
                    if (hdr_cnt_reg == 4'd0) begin
                        first_next = in_byte;
                        len_next   = 64'd0;
                        key_next   = 32'd0;
                    end else if (hdr_cnt_reg == 4'd1) begin
                        second_next = in_byte;
                        len_next    = (ext_cur == 4'd0) ? {57'd0, in_byte[6:0]} : 64'd0;
                    end else if (hdr_cnt_reg < HDR_BASE_BYTES + ext_cur) begin
                        len_next = {len_reg[55:0], in_byte};
                    end else begin
                        key_next = {key_reg[23:0], in_byte};
                    end
                    hdr_cnt_next = cnt_inc;

                    if (cnt_inc >= HDR_BASE_BYTES && cnt_inc >= total) begin
                        // Check the finished header, first match wins
                        hdr_cnt_next = 4'd0;
                        if (!is_ctrl && !is_data) begin
                            st = ST_BAD_OPCODE;
                        end else if (len_next > {32'd0, max_payload_reg}) begin
                            st = ST_TOO_LARGE;
                        end else if (is_ctrl && len_next > CTRL_MAX_LEN) begin
                            st = ST_LONG_CTRL;
                        end else if (fb_cur[5:4] != 2'b00) begin
                            st = ST_RSV23;
                        end else if (fb_cur[6] && (op == OP_CONT || is_ctrl)) begin
                            st = ST_RSV1;
                        end else if (!fb_cur[7] && is_ctrl) begin
                            st = ST_FRAG_CTRL;
                        end
                        res_valid          = 1'b1;
                        res.kind           = KIND_HEADER;
                        res.status         = st;
                        res.opcode         = fb_cur[3:0];
                        res.fin            = fb_cur[7];
                        res.rsv1           = fb_cur[6];
                        res.masked         = sb_cur[7];
                        res.payload_length = sat_len(len_next);
                        if (st != ST_GOOD) begin
                            halted_next = 1'b1;
                            res.last    = 1'b1;
                        end else begin
                            key_idx_next = 2'd0;
                            if (len_next == 64'd0) begin
                                res.last = 1'b1;
                            end else begin
                                remain_next = len_next[31:0];
                                phase_next  = PH_PAYLOAD;
                            end
                        end
                    end
                end
                default: begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    // Hold the limit register and the frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
            phase_reg       <= PH_HEADER;
            hdr_cnt_reg     <= 4'd0;
            first_reg       <= 8'd0;
            second_reg      <= 8'd0;
            len_reg         <= 64'd0;
            key_reg         <= 32'd0;
            remain_reg      <= 32'd0;
            key_idx_reg     <= 2'd0;
            halted_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_payload_reg <= cfg_wdata;
            end
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            len_reg     <= len_next;
            key_reg     <= key_next;
            remain_reg  <= remain_next;
            key_idx_reg <= key_idx_next;
            halted_reg  <= halted_next;
        end
    end

endmodule

### sv/wsdf_skid.sv
// Two-entry output register with skid stage for result transactions.
module wsdf_skid (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  wsdf_pkg::wsdf_result_t in_data,
    output logic                  in_ready,
    output logic                  out_valid,
    output wsdf_pkg::wsdf_result_t out_data,
    input  logic                  out_ready
);
    import wsdf_pkg::*;

    logic         out_valid_reg;
    logic         skid_valid_reg;
    wsdf_result_t out_data_reg;
    wsdf_result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control: load output, park in skid, or drain skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || out_ready) begin
            out_valid_reg <= in_valid;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload moves without reset
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_ready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (!out_valid_reg || out_ready) begin
            out_data_reg <= in_data;
        end else begin
            skid_data_reg <= in_data;
        end
    end

endmodule
